// ----- rtl/mqts_pkg.sv -----
// shared types, codes and helpers for the min queue built from two stacks
`timescale 1ns / 1ps
package mqts_pkg;

   localparam int VALUE_WIDTH   = 32;
   localparam int STATUS_WIDTH  = 2;
   localparam int DEFAULT_DEPTH = 16;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_UNDERFLOW = 2'd2;

   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_ZERO          = 32'sh0000_0000;

   // each entry keeps its value and the minimum of every entry below it
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic signed [VALUE_WIDTH-1:0] min_below;
   } entry_type;

   localparam int ENTRY_WIDTH = $bits(entry_type);

   function automatic logic signed [VALUE_WIDTH-1:0] min_of(
      input logic signed [VALUE_WIDTH-1:0] a,
      input logic signed [VALUE_WIDTH-1:0] b
   );
      return (a < b) ? a : b;
   endfunction

   function automatic logic signed [VALUE_WIDTH-1:0] queue_min_of(
      input logic                          have_in,
      input logic signed [VALUE_WIDTH-1:0] in_min,
      input logic                          have_out,
      input logic signed [VALUE_WIDTH-1:0] out_min
   );
      logic signed [VALUE_WIDTH-1:0] result;
      if (have_in && have_out) begin
         result = min_of(in_min, out_min);
      end else if (have_in) begin
         result = in_min;
      end else if (have_out) begin
         result = out_min;
      end else begin
         result = VALUE_ZERO;
      end
      return result;
   endfunction

endpackage

// ----- rtl/mqts_if.sv -----
// request and response channel interfaces of the min queue
`timescale 1ns / 1ps
interface mqts_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 opcode;
   logic signed [mqts_pkg::VALUE_WIDTH-1:0] in_value;

   modport source (output valid, output opcode, output in_value, input ready);
   modport sink (input valid, input opcode, input in_value, output ready);
endinterface

interface mqts_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [mqts_pkg::VALUE_WIDTH-1:0]  out_value;
   logic        [mqts_pkg::STATUS_WIDTH-1:0] status;
   logic signed [mqts_pkg::VALUE_WIDTH-1:0]  queue_min;
   logic                                     is_empty;

   modport source (output valid, output out_value, output status, output queue_min,
                   output is_empty, input ready);
   modport sink (input valid, input out_value, input status, input queue_min,
                 input is_empty, output ready);
endinterface

// ----- rtl/mqts_ram.sv -----
// generic single write port, single read port ram with registered read data
`timescale 1ns / 1ps
module mqts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/min_queue_two_stacks_unit.sv -----
// top level of the min queue built from two stacks
//
// req_ch takes one operation per item: opcode 0 enqueues in_value, opcode 1
// dequeues the oldest value. rsp_ch returns exactly one item per request with
// the dequeued value, a status code, the queue minimum and an empty flag.
// Both channels use a valid/ready handshake.
// An enqueue answers in the cycle after it is accepted. A dequeue with data
// in the output stack reads its top from the output stack ram in ST_POP and
// then registers the response. When the output stack is empty the input
// stack is moved across first, one entry per cycle through the input stack
// ram read port, and the last entry read is handed out as the answer. Each
// value crosses once. An empty-queue dequeue answers in the cycle after it
// is accepted.
// One operation is in flight at a time; a new request is taken once the
// response register is empty or being drained in the same cycle, so a stalled
// receiver holds the result and blocks new requests.
// Reset empties both stacks at once; no clearing pass is needed.
`timescale 1ns / 1ps
module min_queue_two_stacks_unit #(
   parameter int STACK_DEPTH = mqts_pkg::DEFAULT_DEPTH
) (
   input logic       clock,
   input logic       reset,
   mqts_req_if.sink  req_ch,
   mqts_rsp_if.source rsp_ch
);

   import mqts_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_XFER = 2'd1;
   localparam logic [1:0] ST_POP  = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [CW-1:0]                 in_cnt_ff, in_cnt_in;
   logic [CW-1:0]                 out_cnt_ff, out_cnt_in;
   logic signed [VALUE_WIDTH-1:0] in_min_ff, in_min_in;
   logic signed [VALUE_WIDTH-1:0] out_min_ff, out_min_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_WIDTH-1:0]  rsp_value_ff, rsp_value_in;
   logic        [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;
   logic signed [VALUE_WIDTH-1:0]  rsp_qmin_ff, rsp_qmin_in;
   logic                           rsp_empty_ff, rsp_empty_in;

   logic                   in_wr_en, in_rd_en, out_wr_en, out_rd_en;
   logic [AW-1:0]          in_wr_addr, in_rd_addr, out_wr_addr, out_rd_addr;
   entry_type              in_wr_entry, out_wr_entry, in_rd_entry, out_rd_entry;
   logic [ENTRY_WIDTH-1:0] in_rd_data, out_rd_data;

   logic                          req_ready;
   logic                          req_fire;
   logic [CW-1:0]                 in_top_idx, out_top_idx;
   logic signed [VALUE_WIDTH-1:0] push_min, xfer_min;

   mqts_ram #(
      .WIDTH(ENTRY_WIDTH),
      .DEPTH(STACK_DEPTH)
   ) in_stack_ram (
      .clock  (clock),
      .wr_en  (in_wr_en),
      .wr_addr(in_wr_addr),
      .wr_data(in_wr_entry),
      .rd_en  (in_rd_en),
      .rd_addr(in_rd_addr),
      .rd_data(in_rd_data)
   );

   mqts_ram #(
      .WIDTH(ENTRY_WIDTH),
      .DEPTH(STACK_DEPTH)
   ) out_stack_ram (
      .clock  (clock),
      .wr_en  (out_wr_en),
      .wr_addr(out_wr_addr),
      .wr_data(out_wr_entry),
      .rd_en  (out_rd_en),
      .rd_addr(out_rd_addr),
      .rd_data(out_rd_data)
   );

   assign in_rd_entry  = entry_type'(in_rd_data);
   assign out_rd_entry = entry_type'(out_rd_data);

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire  = req_ch.valid && req_ready;

   assign in_top_idx  = in_cnt_ff - CW'(1);
   assign out_top_idx = out_cnt_ff - CW'(1);
   assign push_min    = (in_cnt_ff == '0) ? req_ch.in_value
                                          : min_of(req_ch.in_value, in_min_ff);
   assign xfer_min    = (out_cnt_ff == '0) ? in_rd_entry.value
                                           : min_of(in_rd_entry.value, out_min_ff);

   always_comb begin
      state_in      = state_ff;
      in_cnt_in     = in_cnt_ff;
      out_cnt_in    = out_cnt_ff;
      in_min_in     = in_min_ff;
      out_min_in    = out_min_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_qmin_in   = rsp_qmin_ff;
      rsp_empty_in  = rsp_empty_ff;

      in_wr_en     = 1'b0;
      in_wr_addr   = in_cnt_ff[AW-1:0];
      in_wr_entry  = '{value: req_ch.in_value, min_below: in_min_ff};
      in_rd_en     = 1'b0;
      in_rd_addr   = in_top_idx[AW-1:0];
      out_wr_en    = 1'b0;
      out_wr_addr  = out_cnt_ff[AW-1:0];
      out_wr_entry = '{value: in_rd_entry.value, min_below: out_min_ff};
      out_rd_en    = 1'b0;
      out_rd_addr  = out_top_idx[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.opcode == OP_ENQUEUE) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = VALUE_ZERO;
                  if (in_cnt_ff == CW'(STACK_DEPTH)) begin
                     rsp_status_in = STATUS_OVERFLOW;
                     rsp_qmin_in   = queue_min_of(1'b1, in_min_ff,
                                                  out_cnt_ff != '0, out_min_ff);
                     rsp_empty_in  = 1'b0;
                  end else begin
                     in_wr_en      = 1'b1;
                     in_min_in     = push_min;
                     in_cnt_in     = in_cnt_ff + CW'(1);
                     rsp_status_in = STATUS_OK;
                     rsp_qmin_in   = queue_min_of(1'b1, push_min,
                                                  out_cnt_ff != '0, out_min_ff);
                     rsp_empty_in  = 1'b0;
                  end
               end else if (out_cnt_ff != '0) begin
                  out_rd_en  = 1'b1;
                  out_cnt_in = out_top_idx;
                  state_in   = ST_POP;
               end else if (in_cnt_ff != '0) begin
                  in_rd_en  = 1'b1;
                  in_cnt_in = in_top_idx;
                  state_in  = ST_XFER;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = VALUE_MOST_NEGATIVE;
                  rsp_status_in = STATUS_UNDERFLOW;
                  rsp_qmin_in   = VALUE_ZERO;
                  rsp_empty_in  = 1'b1;
               end
            end
         end
         ST_XFER: begin
            if (in_cnt_ff != '0) begin
               out_wr_en  = 1'b1;
               out_min_in = xfer_min;
               out_cnt_in = out_cnt_ff + CW'(1);
               in_rd_en   = 1'b1;
               in_cnt_in  = in_top_idx;
            end else begin
               // last entry moved is the new top, hand it out without storing it
               rsp_valid_in  = 1'b1;
               rsp_value_in  = in_rd_entry.value;
               rsp_status_in = STATUS_OK;
               rsp_qmin_in   = queue_min_of(1'b0, in_min_ff, out_cnt_ff != '0, out_min_ff);
               rsp_empty_in  = (out_cnt_ff == '0);
               state_in      = ST_IDLE;
            end
         end
         ST_POP: begin
            out_min_in    = out_rd_entry.min_below;
            rsp_valid_in  = 1'b1;
            rsp_value_in  = out_rd_entry.value;
            rsp_status_in = STATUS_OK;
            rsp_qmin_in   = queue_min_of(in_cnt_ff != '0, in_min_ff,
                                         out_cnt_ff != '0, out_rd_entry.min_below);
            rsp_empty_in  = (in_cnt_ff == '0) && (out_cnt_ff == '0);
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_cnt_ff    <= '0;
         out_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_cnt_ff    <= in_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_min_ff     <= in_min_in;
      out_min_ff    <= out_min_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_qmin_ff   <= rsp_qmin_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign req_ch.ready     = req_ready;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_value = rsp_value_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.queue_min = rsp_qmin_ff;
   assign rsp_ch.is_empty  = rsp_empty_ff;

endmodule
